/* rtl/core/swhm_pkg.sv */
// Shared types and constants of the sliding window histogram match block.
package swhm_pkg;

  localparam int TYPE_W  = 2;
  localparam int COLOR_W = 8;
  localparam int AMT_W   = 11;
  localparam int TOTAL_W = 32;

  localparam logic [TYPE_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SYMBOL  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RESTART = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [AMT_W-1:0] req;
    logic [AMT_W-1:0] cnt;
  } count_entry_t;

  typedef struct packed {
    logic               match;
    logic               window_full;
    logic [TOTAL_W-1:0] match_total;
    logic               status;
  } result_t;

endpackage

/* rtl/core/swhm_if.sv */
// Request and result channel interfaces of the sliding window histogram match block.
interface swhm_req_if import swhm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [COLOR_W-1:0] color;
  logic [AMT_W-1:0]   amount;

  modport source (output valid, req_type, color, amount, input ready);
  modport sink (input valid, req_type, color, amount, output ready);
endinterface

interface swhm_rsp_if import swhm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               match;
  logic               window_full;
  logic [TOTAL_W-1:0] match_total;
  logic               status;

  modport source (output valid, match, window_full, match_total, status, input ready);
  modport sink (input valid, match, window_full, match_total, status, output ready);
endinterface

/* rtl/core/swhm_count_tbl.sv */
// Per-colour table of required and current counts, cleared by a pass after reset.
module swhm_count_tbl import swhm_pkg::*; #(
  parameter int NUM_COLORS = 256,
  localparam int CA_W = $clog2(NUM_COLORS)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [CA_W-1:0] addr_a,
  input  logic [CA_W-1:0] addr_b,
  input  logic         we,
  input  logic [CA_W-1:0] waddr,
  input  count_entry_t wdata,
  input  logic         clear_cnt,
  output logic         busy,
  output count_entry_t data_a,
  output count_entry_t data_b
);

  count_entry_t    mem [NUM_COLORS];
  count_entry_t    rd_a;
  count_entry_t    rd_b;
  logic [CA_W-1:0] addr_a_q;
  logic [CA_W-1:0] addr_b_q;
  logic [NUM_COLORS-1:0] cnt_vld;
  logic [NUM_COLORS-1:0] cnt_vld_next;
  logic            lw_vld;
  logic [CA_W-1:0] lw_addr;
  count_entry_t    lw_data;
  logic [CA_W-1:0] init_addr;
  logic            mem_we;
  logic [CA_W-1:0] mem_waddr;
  count_entry_t    mem_wdata;

  // While the clearing pass runs it owns the write port.
  assign mem_we    = busy || we;
  assign mem_waddr = busy ? init_addr : waddr;
  assign mem_wdata = busy ? count_entry_t'('0) : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a     <= mem[addr_a];
    rd_b     <= mem[addr_b];
    addr_a_q <= addr_a;
    addr_b_q <= addr_b;
    lw_addr  <= waddr;
    lw_data  <= wdata;
  end

  always_comb begin
    cnt_vld_next = clear_cnt ? '0 : cnt_vld;
    if (we) begin
      cnt_vld_next[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      init_addr <= '0;
      cnt_vld   <= '0;
      lw_vld    <= 1'b0;
    end else begin
      lw_vld  <= we;
      cnt_vld <= cnt_vld_next;
      if (busy) begin
        init_addr <= CA_W'(init_addr + 1'b1);
        if (32'(init_addr) == 32'(NUM_COLORS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // A write in the same cycle as the read is taken from the bypass register.
  always_comb begin
    if (lw_vld && lw_addr == addr_a_q) begin
      data_a = lw_data;
    end else begin
      data_a.req = rd_a.req;
      data_a.cnt = cnt_vld[addr_a_q] ? rd_a.cnt : '0;
    end
    if (lw_vld && lw_addr == addr_b_q) begin
      data_b = lw_data;
    end else begin
      data_b.req = rd_b.req;
      data_b.cnt = cnt_vld[addr_b_q] ? rd_b.cnt : '0;
    end
  end

endmodule

/* rtl/core/swhm_window_store.sv */
// Circular store of the colours currently inside the window.
module swhm_window_store import swhm_pkg::*; #(
  parameter int MAX_WINDOW = 1024,
  localparam int WP_W = $clog2(MAX_WINDOW)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [WP_W-1:0]    waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic [WP_W-1:0]    raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/swhm_out_queue.sv */
// Two-entry result queue that drives the result channel.
module swhm_out_queue import swhm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  result_t           push_data,
  output logic [QCNT_W-1:0] count,
  swhm_rsp_if.source        rsp
);

  result_t           entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign pop             = rsp.valid && rsp.ready;
  assign rsp.valid       = count != '0;
  assign rsp.match       = entry[rd_ptr].match;
  assign rsp.window_full = entry[rd_ptr].window_full;
  assign rsp.match_total = entry[rd_ptr].match_total;
  assign rsp.status      = entry[rd_ptr].status;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10: count <= QCNT_W'(count + 1'b1);
        2'b01: count <= QCNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/sliding_window_histogram_match.sv */
// Top level of the sliding window histogram match block.
//
// Each request transaction on req loads one colour's required count, streams one
// symbol or restarts the stream; each yields exactly one result transaction on rsp.
// The window length is the sum of the required counts. A load also restarts.
// A result is registered through the first and second stages and is pushed from
// the second into the output queue. No new request is taken while the first stage
// holds one. A symbol writes the count table for the arriving colour and, once the
// window is full, for the departing one; the table has a single write port, and its
// two read ports are bypassed from the last write.
// Reset starts a pass that writes zero to every count table entry, one per cycle, so
// req.ready stays low after reset is released until the pass ends; the window length
// and the match total are cleared at once.
// A restart clears the current counts at once through per-entry valid bits.
// Results wait in a two-entry queue; when rsp stalls, req.ready falls as soon as the
// queue and the transaction in progress would fill it, and nothing is lost.
module sliding_window_histogram_match import swhm_pkg::*; #(
  parameter int NUM_COLORS = 256,
  parameter int MAX_WINDOW = 1024
) (
  input  logic       clk,
  input  logic       rst,
  swhm_req_if.sink   req,
  swhm_rsp_if.source rsp
);

  localparam int CA_W    = $clog2(NUM_COLORS);
  localparam int WP_W    = $clog2(MAX_WINDOW);
  localparam int SEEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int WL_W    = AMT_W + CA_W;
  localparam int TALLY_W = $clog2(NUM_COLORS + 1);
  localparam int CMP_W   = (WL_W > SEEN_W) ? WL_W : SEEN_W;
  localparam int EXT_W   = (CA_W > COLOR_W) ? CA_W : COLOR_W;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_EMPTY   = 3'd3;
  localparam logic [2:0] OP_SYMBOL  = 3'd4;

  logic [WL_W-1:0]    wl;
  logic [TALLY_W-1:0] nz;
  logic [TALLY_W-1:0] tally;
  logic [WP_W-1:0]    wp;
  logic [SEEN_W-1:0]  seen;
  logic [TOTAL_W-1:0] total;

  logic               accept;
  logic               color_ok;
  logic [2:0]         op_in;
  logic               full_in;
  logic [WP_W-1:0]    wp_inc;
  logic [SEEN_W-1:0]  seen_inc;
  logic [WP_W:0]      slot_sum;
  logic [WP_W:0]      wl_slot;
  logic [WP_W:0]      slot_diff;
  logic [WP_W-1:0]    slot;
  logic [EXT_W-1:0]   color_ext;
  logic [CA_W-1:0]    caddr_in;

  logic               s1_vld;
  logic [2:0]         s1_op;
  logic               s1_full;
  logic [CA_W-1:0]    s1_addr;
  logic [AMT_W-1:0]   s1_amount;
  logic               s2_vld;
  logic [2:0]         s2_op;
  logic               s2_full;
  logic [CA_W-1:0]    s2_addr;

  count_entry_t       ent_a;
  count_entry_t       ent_b;
  count_entry_t       wdata;
  logic               we;
  logic [CA_W-1:0]    waddr;
  logic               clear_cnt;
  logic               tbl_busy;
  logic [CA_W-1:0]    addr_b;
  logic [EXT_W-1:0]   old_ext;
  logic [COLOR_W-1:0] old_color;

  logic [AMT_W-1:0]   up_cnt;
  logic [AMT_W-1:0]   dn_cnt;
  logic               up_was;
  logic               up_now;
  logic               dn_was;
  logic               dn_now;
  logic [TALLY_W-1:0] tally_up;
  logic [TALLY_W-1:0] tally_dn;
  logic [WL_W-1:0]    wl_next;
  logic [TALLY_W-1:0] nz_next;
  logic               s2_match;
  logic               s2_window_full;
  logic [TOTAL_W-1:0] total_next;
  result_t            push_data;
  logic [QCNT_W-1:0]  q_cnt;

  // Request decode.
  assign req.ready = !tbl_busy && !s1_vld &&
                     (32'(q_cnt) + 32'(s2_vld) < 32'(QUEUE_DEPTH));
  assign accept    = req.valid && req.ready;
  assign color_ok  = 32'(req.color) < 32'(NUM_COLORS);
  assign color_ext = EXT_W'(req.color);
  assign caddr_in  = color_ext[CA_W-1:0];

  always_comb begin
    case (req.req_type)
      REQ_LOAD:    op_in = color_ok ? OP_LOAD : OP_NONE;
      REQ_RESTART: op_in = OP_RESTART;
      REQ_SYMBOL: begin
        if (!color_ok || 32'(wl) > 32'(MAX_WINDOW)) begin
          op_in = OP_NONE;
        end else if (wl == '0) begin
          op_in = OP_EMPTY;
        end else begin
          op_in = OP_SYMBOL;
        end
      end
      default: op_in = OP_NONE;
    endcase
  end

  assign seen_inc = (32'(seen) < 32'(MAX_WINDOW)) ? SEEN_W'(seen + 1'b1) : seen;
  assign wp_inc   = (32'(wp) == 32'(MAX_WINDOW - 1)) ? '0 : WP_W'(wp + 1'b1);
  assign full_in  = CMP_W'(seen_inc) >= CMP_W'(wl);

  // The departing colour sits window-length entries behind the advanced pointer.
  assign slot_sum  = {1'b0, wp_inc};
  assign wl_slot   = (WP_W + 1)'(wl);
  assign slot_diff = (slot_sum >= wl_slot) ? slot_sum - wl_slot
                                           : slot_sum + (WP_W + 1)'(MAX_WINDOW) - wl_slot;
  assign slot      = slot_diff[WP_W-1:0];

  swhm_window_store #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (accept && op_in == OP_SYMBOL),
    .waddr (wp),
    .wdata (req.color),
    .raddr (slot),
    .rdata (old_color)
  );

  assign old_ext = EXT_W'(old_color);
  assign addr_b  = old_ext[CA_W-1:0];

  swhm_count_tbl #(
    .NUM_COLORS (NUM_COLORS)
  ) u_counts (
    .clk       (clk),
    .rst       (rst),
    .addr_a    (caddr_in),
    .addr_b    (addr_b),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .clear_cnt (clear_cnt),
    .busy      (tbl_busy),
    .data_a    (ent_a),
    .data_b    (ent_b)
  );

  // First stage: arriving colour, loads and restarts.
  assign up_cnt = AMT_W'(ent_a.cnt + 1'b1);
  assign up_was = ent_a.cnt != ent_a.req;
  assign up_now = up_cnt != ent_a.req;

  always_comb begin
    tally_up = tally;
    if (up_now && !up_was) begin
      tally_up = TALLY_W'(tally + 1'b1);
    end else if (up_was && !up_now && tally != '0) begin
      tally_up = TALLY_W'(tally - 1'b1);
    end
  end

  always_comb begin
    wl_next = wl;
    nz_next = nz;
    if (s1_op == OP_LOAD) begin
      wl_next = wl - WL_W'(ent_a.req) + WL_W'(s1_amount);
      nz_next = TALLY_W'(nz - TALLY_W'(ent_a.req != '0) + TALLY_W'(s1_amount != '0));
    end
  end

  // Second stage: departing colour and the result.
  assign dn_cnt = (ent_b.cnt != '0) ? AMT_W'(ent_b.cnt - 1'b1) : ent_b.cnt;
  assign dn_was = ent_b.cnt != ent_b.req;
  assign dn_now = dn_cnt != ent_b.req;

  always_comb begin
    tally_dn = tally;
    if (dn_now && !dn_was) begin
      tally_dn = TALLY_W'(tally + 1'b1);
    end else if (dn_was && !dn_now && tally != '0) begin
      tally_dn = TALLY_W'(tally - 1'b1);
    end
  end

  assign s2_window_full = (s2_op == OP_EMPTY) || (s2_op == OP_SYMBOL && s2_full);
  assign s2_match       = (s2_op == OP_EMPTY) || (s2_op == OP_SYMBOL && s2_full && tally == '0);
  assign total_next     = (s2_match && total != '1) ? TOTAL_W'(total + 1'b1) : total;

  // The two stages never hold a transaction at once, so one write port serves both.
  always_comb begin
    we          = 1'b0;
    waddr       = s1_addr;
    wdata.req   = ent_a.req;
    wdata.cnt   = up_cnt;
    if (s1_vld && s1_op == OP_LOAD) begin
      we        = 1'b1;
      wdata.req = s1_amount;
      wdata.cnt = '0;
    end else if (s1_vld && s1_op == OP_SYMBOL) begin
      we        = 1'b1;
    end else if (s2_vld && s2_op == OP_SYMBOL && s2_full) begin
      we        = 1'b1;
      waddr     = s2_addr;
      wdata.req = ent_b.req;
      wdata.cnt = dn_cnt;
    end
  end

  assign clear_cnt = s1_vld && (s1_op == OP_LOAD || s1_op == OP_RESTART);

  always_ff @(posedge clk) begin
    s1_op     <= op_in;
    s1_full   <= full_in;
    s1_addr   <= caddr_in;
    s1_amount <= req.amount;
    s2_op     <= s1_op;
    s2_full   <= s1_full;
    s2_addr   <= addr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      wl     <= '0;
      nz     <= '0;
      tally  <= '0;
      wp     <= '0;
      seen   <= '0;
      total  <= '0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      if (accept && op_in == OP_SYMBOL) begin
        wp   <= wp_inc;
        seen <= seen_inc;
      end
      if (s1_vld) begin
        case (s1_op)
          OP_LOAD, OP_RESTART: begin
            wl    <= wl_next;
            nz    <= nz_next;
            tally <= nz_next;
            wp    <= '0;
            seen  <= '0;
            total <= '0;
          end
          OP_SYMBOL: tally <= tally_up;
          default: ;
        endcase
      end
      if (s2_vld) begin
        total <= total_next;
        if (s2_op == OP_SYMBOL && s2_full) begin
          tally <= tally_dn;
        end
      end
    end
  end

  assign push_data.match       = s2_match;
  assign push_data.window_full = s2_window_full;
  assign push_data.match_total = total_next;
  assign push_data.status      = 32'(wl) > 32'(MAX_WINDOW);

  swhm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_vld),
    .push_data (push_data),
    .count     (q_cnt),
    .rsp       (rsp)
  );

  assert property (@(posedge clk) disable iff (rst) !(s1_vld && s2_vld))
    else $error("Both pipeline stages hold a transaction.");

  assert property (@(posedge clk) disable iff (rst) s2_vld |-> q_cnt < QCNT_W'(QUEUE_DEPTH))
    else $error("Result queue has no room for a finishing transaction.");

  assert property (@(posedge clk) disable iff (rst)
    32'(tally) <= 32'(NUM_COLORS) && 32'(nz) <= 32'(NUM_COLORS))
    else $error("Mismatch tally exceeds the number of colours.");

  assert property (@(posedge clk) disable iff (rst) 32'(wp) < 32'(MAX_WINDOW))
    else $error("Window pointer out of range.");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the sliding window histogram match block.
`timescale 1ns / 100ps

module tb;
  import swhm_pkg::*;

  localparam int NCOLORS    = 256;
  localparam int WINDOW_MAX = 1024;
  localparam int LATENCY    = 3;
  localparam int QUIET_MAX  = 2000;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  swhm_req_if req_bus ();
  swhm_rsp_if rsp_bus ();

  sliding_window_histogram_match #(
    .NUM_COLORS(NCOLORS),
    .MAX_WINDOW(WINDOW_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the block.
  logic [AMT_W-1:0]   need_cnt [NCOLORS];
  logic [AMT_W-1:0]   seen_cnt [NCOLORS];
  logic [COLOR_W-1:0] ring [WINDOW_MAX];
  logic [9:0]         ring_wr;
  int unsigned        off_colours;
  int unsigned        win_len;
  int unsigned        filled;
  logic [TOTAL_W-1:0] hits_total;

  result_t     expected_q [$];
  int          err_cnt = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_hits = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b0;
  logic        sink_ready = 1'b0;
  int          stall_left = 0;

  assign rsp_bus.ready = sink_ready;

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  function automatic void clear_stream();
    off_colours = 0;
    for (int c = 0; c < NCOLORS; c++) begin
      seen_cnt[c] = '0;
      if (need_cnt[c] != 0) off_colours++;
    end
    ring_wr    = '0;
    filled     = 0;
    hits_total = '0;
  endfunction

  function automatic void move_count(input logic [COLOR_W-1:0] c, input bit up);
    bit was_off;
    bit now_off;
    was_off = seen_cnt[c] != need_cnt[c];
    if (up) seen_cnt[c] = seen_cnt[c] + 1'b1;
    else if (seen_cnt[c] != 0) seen_cnt[c] = seen_cnt[c] - 1'b1;
    now_off = seen_cnt[c] != need_cnt[c];
    if (now_off && !was_off) off_colours++;
    else if (was_off && !now_off && off_colours != 0) off_colours--;
  endfunction

  function automatic result_t predict_window(input logic [TYPE_W-1:0] kind,
                                             input logic [COLOR_W-1:0] col,
                                             input logic [AMT_W-1:0] amt);
    result_t r;
    logic [9:0] slot;
    r = '0;
    case (kind)
      REQ_LOAD: begin
        win_len = win_len - need_cnt[col] + amt;
        need_cnt[col] = amt;
        clear_stream();
      end
      REQ_RESTART: begin
        clear_stream();
      end
      REQ_SYMBOL: begin
        if (win_len <= WINDOW_MAX) begin
          if (win_len == 0) begin
            r.match = 1'b1;
            r.window_full = 1'b1;
          end else begin
            ring[ring_wr] = col;
            ring_wr = ring_wr + 1'b1;
            move_count(col, 1'b1);
            if (filled < WINDOW_MAX) filled++;
            if (filled >= win_len) begin
              slot = ring_wr - 10'(win_len);
              r.window_full = 1'b1;
              r.match = off_colours == 0;
              move_count(ring[slot], 1'b0);
            end
          end
          if (r.match && hits_total != '1) hits_total++;
        end
      end
      default: begin
      end
    endcase
    r.match_total = hits_total;
    r.status = win_len > WINDOW_MAX;
    return r;
  endfunction

  task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [COLOR_W-1:0] col,
                           input logic [AMT_W-1:0] amt);
    result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.color    <= col;
    req_bus.amount   <= amt;
    do @(posedge clk); while (!req_bus.ready);
    r = predict_window(kind, col, amt);
    if (r.match) n_hits++;
    expected_q.insert(expected_q.size(), r);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic clear_needs();
    for (int c = 0; c < NCOLORS; c++) begin
      if (need_cnt[c] != 0) send_item(REQ_LOAD, COLOR_W'(c), '0);
    end
  endtask

  task automatic test_empty_window();
    send_item(REQ_SYMBOL, 8'd0, 11'd0);
    send_item(REQ_SYMBOL, 8'd255, 11'd2047);
    send_item(REQ_UNUSED, 8'd7, 11'd2047);
    send_item(REQ_RESTART, 8'd255, 11'd1024);
    send_item(REQ_SYMBOL, 8'd128, 11'd5);
  endtask

  task automatic test_load_limits();
    send_item(REQ_LOAD, 8'd255, 11'd2047);
    send_item(REQ_SYMBOL, 8'd255, 11'd0);
    send_item(REQ_LOAD, 8'd255, 11'd1024);
    send_item(REQ_SYMBOL, 8'd3, 11'd0);
    send_item(REQ_RESTART, 8'd0, 11'd0);
    send_item(REQ_LOAD, 8'd255, 11'd0);
    send_item(REQ_LOAD, 8'd0, 11'd1);
    send_item(REQ_SYMBOL, 8'd0, 11'd0);
    send_item(REQ_SYMBOL, 8'd255, 11'd0);
    send_item(REQ_LOAD, 8'd255, 11'd1);
    send_item(REQ_SYMBOL, 8'd0, 11'd0);
    send_item(REQ_SYMBOL, 8'd255, 11'd0);
    send_item(REQ_SYMBOL, 8'd255, 11'd0);
    send_item(REQ_SYMBOL, 8'd0, 11'd0);
    send_item(REQ_UNUSED, 8'd0, 11'd0);
    send_item(REQ_LOAD, 8'd0, 11'd0);
    send_item(REQ_LOAD, 8'd255, 11'd0);
  endtask

  // A periodic stream whose period holds every required symbol keeps the window matching.
  task automatic test_widest_window();
    logic [COLOR_W-1:0] period [$];
    logic [COLOR_W-1:0] tmp;
    int j;
    clear_needs();
    send_item(REQ_LOAD, 8'd9, 11'd1000);
    send_item(REQ_LOAD, 8'd200, 11'd24);
    for (int i = 0; i < WINDOW_MAX; i++) period.insert(period.size(), i < 1000 ? 8'd9 : 8'd200);
    for (int i = WINDOW_MAX - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = period[i];
      period[i] = period[j];
      period[j] = tmp;
    end
    for (int i = 0; i < 1100; i++) send_item(REQ_SYMBOL, period[i % WINDOW_MAX], '0);
    send_item(REQ_LOAD, 8'd200, 11'd25);
    send_item(REQ_SYMBOL, 8'd200, '0);
    clear_needs();
  endtask

  task automatic test_random_windows(input int n_items);
    logic [COLOR_W-1:0] period [$];
    logic [COLOR_W-1:0] tmp;
    int first;
    int len;
    int r;
    int j;
    first = n_sent;
    while (n_sent - first < n_items) begin
      clear_needs();
      if ($urandom_range(0, 9) == 0) begin
        send_item(REQ_LOAD, COLOR_W'($urandom_range(0, 255)), AMT_W'($urandom_range(0, 2047)));
      end
      repeat ($urandom_range(1, 4)) begin
        send_item(REQ_LOAD, COLOR_W'($urandom_range(0, 255)), AMT_W'($urandom_range(1, 4)));
      end
      period.delete();
      if (win_len <= 64) begin
        for (int c = 0; c < NCOLORS; c++) begin
          repeat (need_cnt[c]) period.insert(period.size(), COLOR_W'(c));
        end
      end
      for (int i = period.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = period[i];
        period[i] = period[j];
        period[j] = tmp;
      end
      if (period.size() == 0) len = $urandom_range(4, 20);
      else len = period.size() * $urandom_range(2, 8) + $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 63);
        if (r == 0) begin
          send_item(REQ_RESTART, COLOR_W'($urandom_range(0, 255)), AMT_W'($urandom_range(0, 2047)));
        end else if (r == 1) begin
          send_item(REQ_UNUSED, COLOR_W'($urandom_range(0, 255)), AMT_W'($urandom_range(0, 2047)));
        end else if (r < 6 || period.size() == 0) begin
          send_item(REQ_SYMBOL, COLOR_W'($urandom_range(0, 255)), AMT_W'($urandom_range(0, 2047)));
        end else begin
          send_item(REQ_SYMBOL, period[i % period.size()], AMT_W'($urandom_range(0, 2047)));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) sink_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(1, 17);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with none outstanding", 64'd0, 64'd1);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (rsp_bus.match !== want.match)
          report_mismatch("match", 64'(want.match), 64'(rsp_bus.match));
        if (rsp_bus.window_full !== want.window_full)
          report_mismatch("window_full", 64'(want.window_full),
                          64'(rsp_bus.window_full));
        if (rsp_bus.match_total !== want.match_total)
          report_mismatch("match_total", 64'(want.match_total),
                          64'(rsp_bus.match_total));
        if (rsp_bus.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(rsp_bus.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Timed out after %0d cycles with no transaction.", QUIET_MAX);
        $display("sliding_window_histogram_match: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_LOAD;
    req_bus.color    <= '0;
    req_bus.amount   <= '0;
    for (int c = 0; c < NCOLORS; c++) begin
      need_cnt[c] = '0;
      seen_cnt[c] = '0;
    end
    win_len = 0;
    off_colours = 0;
    ring_wr = '0;
    filled = 0;
    hits_total = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_window();
    test_load_limits();
    wait_drained();
    idle_on = 1'b1;
    test_widest_window();
    wait_drained();
    test_random_windows(480);
    wait_drained();
    idle_on = 1'b0;
    test_random_windows(260);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d request transactions, %0d results checked, %0d matching windows.",
             n_sent, n_checked, n_hits);
    $display("Covered empty, oversized and full-store windows, restarts and unused requests.");
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("sliding_window_histogram_match: match");
    end else begin
      $display("sliding_window_histogram_match: mismatch");
    end
    $finish;
  end

endmodule
